// ----- rtl/core/digital_input_qualifier_macros.svh -----
// Assertion macros for the digital input qualifier checker.
// Each macro samples on clk and is disabled while rst is high.
`ifndef DIGITAL_INPUT_QUALIFIER_MACROS_SVH
`define DIGITAL_INPUT_QUALIFIER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define DIQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define DIQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/diq_pkg.sv -----
// Shared types and constants for the digital input qualifier.
// Used by diq_lane, diq_merge and the top level; no dependencies.
`timescale 1ns / 1ps

package diq_pkg;

  // Channels in use (1 to 4); result fields always carry four lanes.
  localparam int CHANNELS  = 4;
  localparam int LANES_MAX = 4;

  localparam int NOW_W   = 32;
  localparam int COUNT_W = 32;
  localparam int MS_W    = 16;
  localparam int MASK_W  = 4;
  localparam int EDGE_W  = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 160;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_SELECT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_ENABLE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_ENABLE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_LEVEL    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_DELAY_MS = 3'd7;

  // Edge select codes; anything else reports both edges
  localparam logic [EDGE_W-1:0] EDGE_RISING_ONLY  = 2'd0;
  localparam logic [EDGE_W-1:0] EDGE_FALLING_ONLY = 2'd1;
  localparam logic [EDGE_W-1:0] EDGE_BOTH         = 2'd2;

  // Register reset values
  localparam logic [MASK_W-1:0] RST_CHANNEL_ENABLE = 4'hF;
  localparam logic [MASK_W-1:0] RST_ALARM_LEVEL    = 4'hF;
  localparam logic [MS_W-1:0]   RST_DEBOUNCE_MS    = 16'd50;

  typedef enum logic [1:0] {
    LVL_UNKNOWN = 2'd0,
    LVL_LOW     = 2'd1,
    LVL_HIGH    = 2'd2
  } lvl_t;

  // Per-lane view of the configuration
  typedef struct packed {
    logic            enable;
    logic            invert;
    logic            count_en;
    logic            alarm_en;
    logic            alarm_level;
    logic            want_rise;
    logic            want_fall;
    logic [MS_W-1:0] debounce_ms;
    logic [MS_W-1:0] alarm_delay_ms;
  } lane_cfg_t;

  // Per-lane result flags after one update
  typedef struct packed {
    logic level;
    logic known;
    logic debouncing;
    logic rising;
    logic falling;
    logic alarm_active;
    logic alarm_raised;
  } lane_flags_t;

endpackage

// ----- rtl/core/diq_lane.sv -----
// One channel of the qualifier: inversion, time debounce, edge filter,
// pulse counter and level alarm. Depends on diq_pkg.
`timescale 1ns / 1ps

module diq_lane (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  diq_pkg::lane_cfg_t             cfg,
  input  logic [diq_pkg::NOW_W-1:0]      now_ms,
  input  logic                           pin,
  input  logic                           clear,
  output diq_pkg::lane_flags_t           flags,
  output logic [diq_pkg::COUNT_W-1:0]    pulse_count
);

  diq_pkg::lvl_t                  conf;
  diq_pkg::lvl_t                  conf_next;
  diq_pkg::lvl_t                  pend;
  diq_pkg::lvl_t                  pend_next;
  diq_pkg::lvl_t                  new_lvl;
  diq_pkg::lvl_t                  alarm_lvl;
  logic [diq_pkg::NOW_W-1:0]      start;
  logic [diq_pkg::NOW_W-1:0]      start_next;
  logic [diq_pkg::NOW_W-1:0]      change_t;
  logic [diq_pkg::NOW_W-1:0]      change_t_next;
  logic [diq_pkg::COUNT_W-1:0]    count;
  logic [diq_pkg::COUNT_W-1:0]    count_base;
  logic [diq_pkg::COUNT_W-1:0]    count_next;
  logic                           alarm;
  logic                           alarm_next;
  logic                           dbf;
  logic                           dbf_next;
  logic                           confirm;
  logic                           rise;
  logic                           fall;
  logic                           raised;
  logic                           delay_met;
  logic [diq_pkg::NOW_W-1:0]      pend_elapsed;
  logic [diq_pkg::NOW_W-1:0]      hold;
  logic [diq_pkg::NOW_W-1:0]      debounce_w;
  logic [diq_pkg::NOW_W-1:0]      delay_w;

  // Wrapping time differences
  assign pend_elapsed = now_ms - start;
  assign hold         = now_ms - change_t;
  assign debounce_w   = {{(diq_pkg::NOW_W - diq_pkg::MS_W){1'b0}}, cfg.debounce_ms};
  assign delay_w      = {{(diq_pkg::NOW_W - diq_pkg::MS_W){1'b0}}, cfg.alarm_delay_ms};

  always_comb begin
    count_base    = clear ? '0 : count;
    conf_next     = conf;
    pend_next     = pend;
    start_next    = start;
    change_t_next = change_t;
    count_next    = count_base;
    alarm_next    = alarm;
    dbf_next      = dbf;
    confirm       = 1'b0;
    rise          = 1'b0;
    fall          = 1'b0;
    raised        = 1'b0;
    new_lvl       = (pin ^ cfg.invert) ? diq_pkg::LVL_HIGH : diq_pkg::LVL_LOW;
    alarm_lvl     = cfg.alarm_level ? diq_pkg::LVL_HIGH : diq_pkg::LVL_LOW;
    // a fresh confirmation has zero hold time
    delay_met     = 1'b0;

    if (cfg.enable) begin
      if (new_lvl != conf) begin
        if (pend != new_lvl) begin
          pend_next  = new_lvl;
          start_next = now_ms;
          dbf_next   = 1'b1;
        end else if (pend_elapsed >= debounce_w) begin
          dbf_next = 1'b0;
          confirm  = 1'b1;
        end
      end else begin
        pend_next = diq_pkg::LVL_UNKNOWN;
        dbf_next  = 1'b0;
      end

      if (confirm) begin
        conf_next     = new_lvl;
        change_t_next = now_ms;
        if (conf == diq_pkg::LVL_LOW && new_lvl == diq_pkg::LVL_HIGH && cfg.want_rise) begin
          rise = 1'b1;
          if (cfg.count_en) begin
            count_next = count_base + {{(diq_pkg::COUNT_W - 1){1'b0}}, 1'b1};
          end
        end else if (conf == diq_pkg::LVL_HIGH && new_lvl == diq_pkg::LVL_LOW &&
                     cfg.want_fall) begin
          fall = 1'b1;
        end
      end

      delay_met = confirm ? (delay_w == '0) : (hold >= delay_w);

      if (cfg.alarm_en && conf_next == alarm_lvl) begin
        if (!alarm && delay_met) begin
          alarm_next = 1'b1;
          raised     = 1'b1;
        end
      end else begin
        alarm_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      conf  <= diq_pkg::LVL_UNKNOWN;
      pend  <= diq_pkg::LVL_UNKNOWN;
      count <= '0;
      alarm <= 1'b0;
      dbf   <= 1'b0;
    end else if (step) begin
      conf     <= conf_next;
      pend     <= pend_next;
      start    <= start_next;
      change_t <= change_t_next;
      count    <= count_next;
      alarm    <= alarm_next;
      dbf      <= dbf_next;
    end
  end

  assign flags.level        = (conf_next == diq_pkg::LVL_HIGH);
  assign flags.known        = (conf_next != diq_pkg::LVL_UNKNOWN);
  assign flags.debouncing   = dbf_next;
  assign flags.rising       = rise;
  assign flags.falling      = fall;
  assign flags.alarm_active = alarm_next;
  assign flags.alarm_raised = raised;
  assign pulse_count        = count_next;

endmodule

// ----- rtl/core/diq_merge.sv -----
// Merging stage: gathers lane flags and counts into one result word and
// holds it in a two-entry output buffer. Depends on diq_pkg.
`timescale 1ns / 1ps

module diq_merge (
  input  logic                          clk,
  input  logic                          rst,
  input  diq_pkg::lane_flags_t          flags  [diq_pkg::LANES_MAX],
  input  logic [diq_pkg::COUNT_W-1:0]   counts [diq_pkg::LANES_MAX],
  input  logic                          in_valid,
  output logic                          in_ready,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [diq_pkg::M_DATA_W-1:0]  m_tdata
);

  localparam int PAD_W = diq_pkg::M_DATA_W - 7 * diq_pkg::LANES_MAX
                         - diq_pkg::LANES_MAX * diq_pkg::COUNT_W;

  logic [diq_pkg::LANES_MAX-1:0]                   lv;
  logic [diq_pkg::LANES_MAX-1:0]                   kn;
  logic [diq_pkg::LANES_MAX-1:0]                   db;
  logic [diq_pkg::LANES_MAX-1:0]                   ri;
  logic [diq_pkg::LANES_MAX-1:0]                   fa;
  logic [diq_pkg::LANES_MAX-1:0]                   aa;
  logic [diq_pkg::LANES_MAX-1:0]                   ar;
  logic [diq_pkg::LANES_MAX*diq_pkg::COUNT_W-1:0]  cnt_flat;
  logic [diq_pkg::M_DATA_W-1:0]                    word;
  logic [diq_pkg::M_DATA_W-1:0]                    out_word;
  logic [diq_pkg::M_DATA_W-1:0]                    skid_word;
  logic                                            out_valid;
  logic                                            skid_valid;

  always_comb begin
    for (int i = 0; i < diq_pkg::LANES_MAX; i++) begin
      lv[i] = flags[i].level;
      kn[i] = flags[i].known;
      db[i] = flags[i].debouncing;
      ri[i] = flags[i].rising;
      fa[i] = flags[i].falling;
      aa[i] = flags[i].alarm_active;
      ar[i] = flags[i].alarm_raised;
      cnt_flat[i*diq_pkg::COUNT_W +: diq_pkg::COUNT_W] = counts[i];
    end
  end

  assign word = {{PAD_W{1'b0}}, cnt_flat, ar, aa, fa, ri, db, kn, lv};

  // Second entry fills only while the first is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || m_tready) begin
        if (skid_valid) begin
          out_word   <= skid_word;
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= in_valid;
          if (in_valid) begin
            out_word <= word;
          end
        end
      end else if (in_valid) begin
        skid_word  <= word;
        skid_valid <= 1'b1;
      end
    end
  end

  assign in_ready = !skid_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_word;

endmodule

// ----- rtl/core/digital_input_qualifier.sv -----
// Digital input qualifier: top level with configuration registers, channel
// lanes and the merging stage. Depends on diq_pkg, diq_lane and diq_merge.
//
// Takes one time-stamped pin sample per clock while s_tready is high and
// returns one registered word for each. Every channel has its own lane with
// two 32-bit time subtractors and a pulse counter, so a whole update
// (debounce check, edge, count and alarm) completes in the accepting cycle.
// A two-word output buffer keeps s_tready high while one result waits on
// m_tready; s_tready drops only when both words are held. There is no
// start-up clearing pass: the block accepts words from the first cycle
// after reset. Configuration writes take effect on the next cycle.
`timescale 1ns / 1ps

module digital_input_qualifier (
  input  logic                              clk,
  input  logic                              rst,
  // fields from bit 0: now_ms[31:0], raw_pins[35:32], clear_counts[39:36]
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [diq_pkg::S_DATA_W-1:0]      s_tdata,
  // fields from bit 0: level_bits[3:0], level_known[7:4], debouncing[11:8],
  // rising_events[15:12], falling_events[19:16], alarm_active[23:20],
  // alarm_raised[27:24], pulse_count_0[59:28], pulse_count_1[91:60],
  // pulse_count_2[123:92], pulse_count_3[155:124], zero fill[159:156]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [diq_pkg::M_DATA_W-1:0]      m_tdata,
  input  logic                              cfg_we,
  input  logic [diq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [diq_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [diq_pkg::MASK_W-1:0]    channel_enable_mask;
  logic [diq_pkg::MASK_W-1:0]    invert_mask;
  logic [diq_pkg::MS_W-1:0]      debounce_ms;
  logic [diq_pkg::EDGE_W-1:0]    edge_select;
  logic [diq_pkg::MASK_W-1:0]    count_enable_mask;
  logic [diq_pkg::MASK_W-1:0]    alarm_enable_mask;
  logic [diq_pkg::MASK_W-1:0]    alarm_level_mask;
  logic [diq_pkg::MS_W-1:0]      alarm_delay_ms;

  logic                          accept;
  logic [diq_pkg::NOW_W-1:0]     now_ms;
  logic [diq_pkg::MASK_W-1:0]    raw_pins;
  logic [diq_pkg::MASK_W-1:0]    clear_counts;

  diq_pkg::lane_flags_t          flags  [diq_pkg::LANES_MAX];
  logic [diq_pkg::COUNT_W-1:0]   counts [diq_pkg::LANES_MAX];

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_enable_mask <= diq_pkg::RST_CHANNEL_ENABLE;
      invert_mask         <= '0;
      debounce_ms         <= diq_pkg::RST_DEBOUNCE_MS;
      edge_select         <= diq_pkg::EDGE_BOTH;
      count_enable_mask   <= '0;
      alarm_enable_mask   <= '0;
      alarm_level_mask    <= diq_pkg::RST_ALARM_LEVEL;
      alarm_delay_ms      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        diq_pkg::REG_CHANNEL_ENABLE: channel_enable_mask <= cfg_data[diq_pkg::MASK_W-1:0];
        diq_pkg::REG_INVERT:         invert_mask         <= cfg_data[diq_pkg::MASK_W-1:0];
        diq_pkg::REG_DEBOUNCE_MS:    debounce_ms         <= cfg_data[diq_pkg::MS_W-1:0];
        diq_pkg::REG_EDGE_SELECT:    edge_select         <= cfg_data[diq_pkg::EDGE_W-1:0];
        diq_pkg::REG_COUNT_ENABLE:   count_enable_mask   <= cfg_data[diq_pkg::MASK_W-1:0];
        diq_pkg::REG_ALARM_ENABLE:   alarm_enable_mask   <= cfg_data[diq_pkg::MASK_W-1:0];
        diq_pkg::REG_ALARM_LEVEL:    alarm_level_mask    <= cfg_data[diq_pkg::MASK_W-1:0];
        diq_pkg::REG_ALARM_DELAY_MS: alarm_delay_ms      <= cfg_data[diq_pkg::MS_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept       = s_tvalid && s_tready;
  assign now_ms       = s_tdata[diq_pkg::NOW_W-1:0];
  assign raw_pins     = s_tdata[diq_pkg::NOW_W +: diq_pkg::MASK_W];
  assign clear_counts = s_tdata[diq_pkg::NOW_W + diq_pkg::MASK_W +: diq_pkg::MASK_W];

  for (genvar i = 0; i < diq_pkg::LANES_MAX; i++) begin : g_lane
    if (i < diq_pkg::CHANNELS) begin : g_used
      diq_pkg::lane_cfg_t lane_cfg;

      assign lane_cfg.enable         = channel_enable_mask[i];
      assign lane_cfg.invert         = invert_mask[i];
      assign lane_cfg.count_en       = count_enable_mask[i];
      assign lane_cfg.alarm_en       = alarm_enable_mask[i];
      assign lane_cfg.alarm_level    = alarm_level_mask[i];
      assign lane_cfg.want_rise      = (edge_select != diq_pkg::EDGE_FALLING_ONLY);
      assign lane_cfg.want_fall      = (edge_select != diq_pkg::EDGE_RISING_ONLY);
      assign lane_cfg.debounce_ms    = debounce_ms;
      assign lane_cfg.alarm_delay_ms = alarm_delay_ms;

      diq_lane u_lane (
        .clk         (clk),
        .rst         (rst),
        .step        (accept),
        .cfg         (lane_cfg),
        .now_ms      (now_ms),
        .pin         (raw_pins[i]),
        .clear       (clear_counts[i]),
        .flags       (flags[i]),
        .pulse_count (counts[i])
      );
    end else begin : g_unused
      assign flags[i]  = '0;
      assign counts[i] = '0;
    end
  end

  diq_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .flags    (flags),
    .counts   (counts),
    .in_valid (accept),
    .in_ready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ----- rtl/core/diq_checker.sv -----
// Port-level checks for the digital input qualifier, bound to the top level.
// Depends on diq_pkg and digital_input_qualifier_macros.svh.
`timescale 1ns / 1ps
`include "digital_input_qualifier_macros.svh"

module diq_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [diq_pkg::M_DATA_W-1:0]  m_tdata
);

  logic [3:0] lv;
  logic [3:0] kn;
  logic [3:0] ri;
  logic [3:0] fa;
  logic [3:0] aa;
  logic [3:0] ar;

  assign lv = m_tdata[3:0];
  assign kn = m_tdata[7:4];
  assign ri = m_tdata[15:12];
  assign fa = m_tdata[19:16];
  assign aa = m_tdata[23:20];
  assign ar = m_tdata[27:24];

  // stalled output word holds
  `DIQ_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "word not held")
  // with the output empty the buffer has room
  `DIQ_ASSERT_IMP(a_room, !m_tvalid, s_tready || !s_tvalid, "input stalled with empty output")
  `DIQ_ASSERT_IMP(a_known, m_tvalid, (lv & ~kn) == 4'h0, "high level reported while unknown")
  `DIQ_ASSERT_IMP(a_edges, m_tvalid, (ri & fa) == 4'h0, "rising and falling edge on one channel")
  `DIQ_ASSERT_IMP(a_raise, m_tvalid, (ar & ~aa) == 4'h0, "alarm raised but not active")

endmodule

bind digital_input_qualifier diq_checker u_diq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
